FILE: hw/rtl/cfcd_pkg.sv
// ============================================================================
// cfcd_pkg
// shared types and codes for the camera frame capture decimator
// ============================================================================
package cfcd_pkg;

    localparam logic [1:0] CMD_START      = 2'd0;
    localparam logic [1:0] CMD_LINE_END   = 2'd1;
    localparam logic [1:0] CMD_FRAME_SYNC = 2'd2;
    localparam logic [1:0] CMD_PIXEL      = 2'd3;

    typedef enum logic [2:0] {
        MODE_WAIT_START = 3'd0,
        MODE_STARTED    = 3'd1,
        MODE_CAPTURING  = 3'd2,
        MODE_READY      = 3'd3,
        MODE_ERROR      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] pixel_word;
    } cfcd_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        image_ready;
        logic        capture_error;
        logic [15:0] frames_done;
    } cfcd_out_t;

endpackage

FILE: hw/rtl/cfcd_core.sv
// ============================================================================
// cfcd_core
// capture state registers, event decode and decimated write address
// ============================================================================
module cfcd_core
    import cfcd_pkg::*;
#(
    parameter int LINES_PER_FRAME = 240,
    parameter int WORDS_PER_LINE  = 160
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  cfcd_in_t  item,
    output cfcd_out_t result
);

    localparam logic [9:0]  LPF_W     = 10'(LINES_PER_FRAME);
    localparam logic [7:0]  WPL_W     = 8'(WORDS_PER_LINE);
    localparam logic [15:0] FRAME_OFS = 16'((LINES_PER_FRAME / 2) * WORDS_PER_LINE);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [9:0]  line_reg;
    logic [9:0]  line_next;
    logic [7:0]  column_reg;
    logic [7:0]  column_next;
    logic        buffer_reg;
    logic        buffer_next;
    logic [15:0] frame_reg;
    logic [15:0] frame_next;

    logic [9:0]  line_inc;
    logic [7:0]  column_inc;
    logic        line_full;
    logic        pixel_write;
    logic [16:0] row_offset;
    logic [15:0] pixel_address;

    assign line_inc    = line_reg + 10'd1;
    assign line_full   = (line_inc >= LPF_W);
    assign column_inc  = column_reg + 8'd1;
    assign pixel_write = (item.cmd == CMD_PIXEL) && (mode_reg == MODE_CAPTURING)
                         && line_reg[0];
    assign row_offset  = 17'(line_reg[9:1]) * 17'(WPL_W);
    assign pixel_address = (buffer_reg ? FRAME_OFS : 16'd0) + row_offset[15:0]
                           + 16'(column_reg);

    // mode transitions
    always_comb
    begin
        mode_next = mode_reg;
        unique case (item.cmd)
            CMD_START:
            begin
                mode_next = MODE_STARTED;
            end
            CMD_LINE_END:
            begin
                if (mode_reg == MODE_CAPTURING && line_full)
                begin
                    mode_next = MODE_READY;
                end
            end
            CMD_FRAME_SYNC:
            begin
                unique case (mode_reg)
                    MODE_STARTED:   mode_next = MODE_CAPTURING;
                    MODE_CAPTURING: mode_next = MODE_ERROR;
                    MODE_ERROR:     mode_next = MODE_WAIT_START;
                    default:        mode_next = mode_reg;
                endcase
            end
            CMD_PIXEL:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // counters, buffer select and result
    always_comb
    begin
        line_next   = line_reg;
        column_next = column_reg;
        buffer_next = buffer_reg;
        frame_next  = frame_reg;
        unique case (item.cmd)
            CMD_START:
            begin
                buffer_next = ~buffer_reg;
            end
            CMD_LINE_END:
            begin
                column_next = 8'd0;
                if (mode_reg == MODE_CAPTURING)
                begin
                    line_next = line_inc;
                    if (line_full)
                    begin
                        frame_next = frame_reg + 16'd1;
                    end
                end
            end
            CMD_FRAME_SYNC:
            begin
                column_next = 8'd0;
                if (mode_reg == MODE_STARTED)
                begin
                    line_next = 10'd0;
                end
                else if (mode_reg == MODE_ERROR)
                begin
                    line_next   = 10'd0;
                    buffer_next = 1'b0;
                    frame_next  = 16'd0;
                end
            end
            CMD_PIXEL:
            begin
                column_next = (column_inc >= WPL_W) ? 8'd0 : column_inc;
            end
        endcase

        result.write_enable  = pixel_write;
        result.write_address = pixel_write ? pixel_address : 16'd0;
        result.write_data    = pixel_write ? item.pixel_word[15:0] : 16'd0;
        result.image_ready   = (mode_next == MODE_READY);
        result.capture_error = (mode_next == MODE_ERROR);
        result.frames_done   = frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_WAIT_START;
            line_reg   <= 10'd0;
            column_reg <= 8'd0;
            buffer_reg <= 1'b0;
            frame_reg  <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            column_reg <= column_next;
            buffer_reg <= buffer_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

FILE: hw/rtl/camera_frame_capture_decimator_unit.sv
// ============================================================================
// camera_frame_capture_decimator_unit
// camera capture controller with 2x decimation in both directions
// ============================================================================
// item channel: item_valid / item_ready with item (cmd, pixel_word), one
// event per transaction: start capture, line end, frame sync or pixel word.
// result channel: result_valid / result_ready with result, exactly one
// transaction per accepted item, in order: the frame memory write (enable,
// address, data) caused by the item, plus image ready, error and frame count
// as they stand after it.
// an accepted item is held in the input register, then passes through the
// decode and address logic into the result register, which drives the
// result channel.
// throughput: one item per cycle while the receiver does not stall; the
// capture state is updated as an item moves from input to result register.
// when the receiver stalls, the result register holds, the input register
// fills behind it and item_ready drops only once both are occupied.
// reset clears the capture state to wait-for-start, buffer 0, frame count 0,
// and empties both registers.
// ============================================================================
module camera_frame_capture_decimator_unit
    import cfcd_pkg::*;
#(
    parameter int LINES_PER_FRAME = 240,
    parameter int WORDS_PER_LINE  = 160
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  cfcd_in_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output cfcd_out_t result
);

    logic      item_valid_reg;
    cfcd_in_t  item_reg;
    logic      result_valid_reg;
    cfcd_out_t result_reg;
    cfcd_out_t result_next;
    logic      result_free;
    logic      stage_advance;

    assign result_free   = !result_valid_reg || result_ready;
    assign stage_advance = item_valid_reg && result_free;
    assign item_ready    = !item_valid_reg || result_free;

    cfcd_core #(
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .WORDS_PER_LINE  (WORDS_PER_LINE)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_advance),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (result_free)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (stage_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no address or data without a write
    a_quiet_when_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.write_enable
        |-> result_reg.write_address == 16'd0 && result_reg.write_data == 16'd0)
        else $error("address or data driven without a write");

    // ready and error are exclusive modes
    a_ready_error_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.image_ready && result_reg.capture_error))
        else $error("image ready and error flagged together");

    // a stalled input stage keeps its item
    a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !stage_advance |=> item_valid_reg && $stable(item_reg))
        else $error("input stage lost a stalled item");

    // a write only happens on a pixel word
    a_write_on_pixel_only: assert property (@(posedge clk) disable iff (!rst_n)
        stage_advance && result_next.write_enable |-> item_reg.cmd == CMD_PIXEL)
        else $error("write issued for a non-pixel event");

endmodule

FILE: sim/camera_frame_capture_decimator_unit_tb.sv
// ============================================================================
// camera_frame_capture_decimator_unit_tb
// self-checking testbench for the camera frame capture decimator
// ============================================================================
// events are queued by a stimulus process and driven on the item channel.
// each accepted event is run through a capture-state predictor that mirrors
// mode, line, column, buffer and frame count, and its expected result is
// queued. results are compared field by field, in order, as they are taken.
// stimulus is a short directed run through the wait, started, capture and
// error modes, then random traffic made mostly of well-formed frames (full
// and aborted) with random pixel content, plus noise. both channels idle and stall at random.
// ============================================================================
module camera_frame_capture_decimator_unit_tb;

    import cfcd_pkg::*;

    localparam int LINES       = 240;
    localparam int WORDS       = 160;
    localparam int FRAME_WORDS = (LINES / 2) * WORDS;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PRINT_LIMIT = 100;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    cfcd_in_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    cfcd_out_t result;

    cfcd_in_t  pending_events[$];
    cfcd_out_t expected_results[$];

    // capture state mirror
    mode_t       cap_mode;
    logic [9:0]  cap_line;
    logic [7:0]  cap_col;
    logic        cap_buf;
    logic [15:0] cap_frames;

    int  mismatches   = 0;
    int  queued_count = 0;
    int  idle_cycles  = 0;
    bit  in_taken     = 1'b0;
    bit  out_taken    = 1'b0;
    int  in_gap       = 0;
    int  out_stall    = 0;
    bit  in_quiet     = 1'b0;
    bit  out_quiet    = 1'b0;

    camera_frame_capture_decimator_unit #(
        .LINES_PER_FRAME(LINES),
        .WORDS_PER_LINE (WORDS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic capture_clear();
        cap_mode   = MODE_WAIT_START;
        cap_line   = '0;
        cap_col    = '0;
        cap_buf    = 1'b0;
        cap_frames = '0;
    endtask

    task automatic capture_step(input cfcd_in_t ev, output cfcd_out_t res);
        int unsigned addr;
        res = '0;
        case (ev.cmd)
            CMD_START:
            begin
                cap_mode = MODE_STARTED;
                cap_buf  = ~cap_buf;
            end
            CMD_LINE_END:
            begin
                cap_col = '0;
                if (cap_mode == MODE_CAPTURING)
                begin
                    cap_line = cap_line + 10'd1;
                    if (cap_line >= LINES)
                    begin
                        cap_mode   = MODE_READY;
                        cap_frames = cap_frames + 16'd1;
                    end
                end
            end
            CMD_FRAME_SYNC:
            begin
                cap_col = '0;
                if (cap_mode == MODE_STARTED)
                begin
                    cap_line = '0;
                    cap_mode = MODE_CAPTURING;
                end
                else if (cap_mode == MODE_CAPTURING)
                    cap_mode = MODE_ERROR;
                else if (cap_mode == MODE_ERROR)
                    capture_clear();
            end
            default:
            begin
                // only odd lines are kept
                if (cap_mode == MODE_CAPTURING && cap_line[0])
                begin
                    addr = int'(cap_buf) * FRAME_WORDS + int'(cap_line >> 1) * WORDS
                           + int'(cap_col);
                    res.write_enable  = 1'b1;
                    res.write_address = addr[15:0];
                    res.write_data    = ev.pixel_word[15:0];
                end
                cap_col = cap_col + 8'd1;
                if (cap_col >= WORDS)
                    cap_col = '0;
            end
        endcase
        res.image_ready   = (cap_mode == MODE_READY);
        res.capture_error = (cap_mode == MODE_ERROR);
        res.frames_done   = cap_frames;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int idle_draw(inout bit quiet);
        if ($urandom_range(0, 29) == 0)
            quiet = !quiet;
        return quiet ? 0 : int'($urandom_range(0, 9));
    endfunction

    task automatic push_event(input logic [1:0] cmd, input logic [31:0] word);
        cfcd_in_t ev;
        ev.cmd        = cmd;
        ev.pixel_word = word;
        pending_events.push_back(ev);
        queued_count++;
    endtask

    task automatic push_line(input int pixels);
        for (int i = 0; i < pixels; i++)
            push_event(CMD_PIXEL, $urandom());
        push_event(CMD_LINE_END, $urandom());
    endtask

    function automatic int line_pixels();
        int r;
        r = $urandom_range(0, 19);
        if (r < 18)
            return 0;
        else if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(4, 8);
    endfunction

    task automatic push_frame(input bit full_last, input bit long_line);
        int n;
        push_event(CMD_START, $urandom());
        push_event(CMD_FRAME_SYNC, $urandom());
        for (int ln = 0; ln < LINES; ln++)
        begin
            n = line_pixels();
            if (ln == LINES - 1 && full_last)
                n = WORDS;
            else if (ln == 1 && long_line)
                n = WORDS + $urandom_range(1, 20);
            push_line(n);
        end
        // events while the image is ready
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_event(2'($urandom_range(1, 3)), $urandom());
    endtask

    task automatic push_aborted_frame();
        int k;
        push_event(CMD_START, $urandom());
        push_event(CMD_FRAME_SYNC, $urandom());
        k = $urandom_range(0, 12);
        for (int i = 0; i < k; i++)
            push_line($urandom_range(0, 4));
        case ($urandom_range(0, 2))
            0:
            begin
                push_event(CMD_FRAME_SYNC, $urandom());
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    push_event(2'($urandom_range(1, 3)) == CMD_FRAME_SYNC ? CMD_PIXEL
                               : 2'($urandom_range(1, 3)), $urandom());
                push_event(CMD_FRAME_SYNC, $urandom());
            end
            1:
            begin
                // restart in the middle of capture
                push_event(CMD_START, $urandom());
                push_event(CMD_FRAME_SYNC, $urandom());
                push_line($urandom_range(0, 3));
                push_line($urandom_range(1, 4));
            end
            default:
            begin
                push_event(CMD_FRAME_SYNC, $urandom());
                push_event(CMD_START, $urandom());
            end
        endcase
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !in_taken))
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                in_gap   = idle_draw(in_quiet);
            end
            if (in_gap > 0)
            begin
                in_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                item       <= pending_events.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // prediction on each accepted transaction
    always @(posedge clk)
    begin
        cfcd_out_t want;
        if (rst_n && item_valid && item_ready)
        begin
            in_taken = 1'b1;
            capture_step(item, want);
            expected_results.push_back(want);
        end
    end

    // result side ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                out_stall = idle_draw(out_quiet);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cfcd_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            out_taken = 1'b1;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'(result), '0);
            else
            begin
                want = expected_results.pop_front();
                if (result.write_enable !== want.write_enable)
                    report_mismatch("write_enable", 32'(result.write_enable),
                                    32'(want.write_enable));
                if (result.write_address !== want.write_address)
                    report_mismatch("write_address", 32'(result.write_address),
                                    32'(want.write_address));
                if (result.write_data !== want.write_data)
                    report_mismatch("write_data", 32'(result.write_data),
                                    32'(want.write_data));
                if (result.image_ready !== want.image_ready)
                    report_mismatch("image_ready", 32'(result.image_ready),
                                    32'(want.image_ready));
                if (result.capture_error !== want.capture_error)
                    report_mismatch("capture_error", 32'(result.capture_error),
                                    32'(want.capture_error));
                if (result.frames_done !== want.frames_done)
                    report_mismatch("frames_done", 32'(result.frames_done),
                                    32'(want.frames_done));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("camera_frame_capture_decimator_unit test failed");
                $finish;
            end
        end
    end

    initial
    begin
        capture_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // events in the wait, started, capture and error modes
        push_event(CMD_PIXEL, 32'hffff_ffff);
        push_event(CMD_LINE_END, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_START, 32'h0);
        push_event(CMD_START, 32'hffff_ffff);
        push_event(CMD_START, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_PIXEL, 32'hffff_ffff);
        push_event(CMD_LINE_END, 32'h0);
        push_event(CMD_PIXEL, 32'hffff_ffff);
        push_event(CMD_PIXEL, 32'h0000_0000);
        push_event(CMD_PIXEL, 32'ha5a5_5a5a);
        push_event(CMD_LINE_END, 32'h0);
        push_event(CMD_START, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_LINE_END, 32'h0);
        push_event(CMD_PIXEL, 32'h1234_ffff);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_PIXEL, 32'h5a5a_a5a5);
        push_event(CMD_LINE_END, 32'h0);
        push_event(CMD_START, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_FRAME_SYNC, 32'h0);
        push_event(CMD_PIXEL, 32'hffff_0001);

        // hold off until the block is empty
        wait_drained();

        queued_count = 0;
        push_frame(1'b1, 1'b1);
        while (queued_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if (queued_count + 400 < RANDOM_ITEMS)
                        push_frame(1'($urandom_range(0, 1)), 1'b0);
                    else
                        push_aborted_frame();
                end
                2, 3, 4, 5, 6:
                    push_aborted_frame();
                default:
                    for (int i = $urandom_range(3, 12); i > 0; i--)
                        push_event(2'($urandom_range(0, 3)), $urandom());
            endcase
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("camera_frame_capture_decimator_unit test passed");
        else
            $display("camera_frame_capture_decimator_unit test failed");
        $finish;
    end

endmodule
